// ----- src/sbt_pkg.sv -----
// Package for the streaming blob tracker: widths, table entry type and the
// per-entry update functions. No dependencies.
package sbt_pkg;

    localparam int COORD_BITS = 10;
    localparam int AREA_W = 2 * COORD_BITS + 1;
    localparam int SUM_W = 3 * COORD_BITS;
    localparam int THR_W = 21;
    localparam int MAX_BLOBS_DEF = 64;
    localparam logic [THR_W-1:0] THRESH_RESET = THR_W'(50);

    typedef logic [COORD_BITS-1:0] coord_t;

    typedef struct packed {
        coord_t run_left;
        coord_t run_right;
        coord_t run_row;
        logic [AREA_W-1:0] area;
        logic [SUM_W-1:0] row_sum;
        logic [SUM_W-1:0] col_sum;
        coord_t box_top;
        coord_t box_bottom;
        coord_t box_left;
        coord_t box_right;
    } entry_t;

    typedef struct packed {
        logic set_en;
        logic clr_en;
        logic clear_all;
    } vld_ctl_t;

    function automatic logic [AREA_W-1:0] sat_area(input logic [AREA_W-1:0] a,
                                                   input logic [AREA_W-1:0] b);
        logic [AREA_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[AREA_W] ? {AREA_W{1'b1}} : s[AREA_W-1:0];
    endfunction

    function automatic logic [SUM_W-1:0] sat_sum(input logic [SUM_W-1:0] a,
                                                 input logic [SUM_W-1:0] b);
        logic [SUM_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
    endfunction

    function automatic entry_t add_pixel(input entry_t e, input coord_t r, input coord_t c);
        entry_t x;
        x = e;
        x.run_right = c;
        x.run_row = r;
        x.area = sat_area(e.area, AREA_W'(1));
        x.row_sum = sat_sum(e.row_sum, SUM_W'(r));
        x.col_sum = sat_sum(e.col_sum, SUM_W'(c));
        if (r < e.box_top) x.box_top = r;
        if (r > e.box_bottom) x.box_bottom = r;
        if (c < e.box_left) x.box_left = c;
        if (c > e.box_right) x.box_right = c;
        return x;
    endfunction

    function automatic entry_t merge_entry(input entry_t from, input entry_t to);
        entry_t x;
        x = to;
        x.run_left = from.run_left;
        x.run_right = from.run_right;
        x.run_row = from.run_row;
        x.area = sat_area(to.area, from.area);
        x.row_sum = sat_sum(to.row_sum, from.row_sum);
        x.col_sum = sat_sum(to.col_sum, from.col_sum);
        if (from.box_top < to.box_top) x.box_top = from.box_top;
        if (from.box_bottom > to.box_bottom) x.box_bottom = from.box_bottom;
        if (from.box_left < to.box_left) x.box_left = from.box_left;
        if (from.box_right > to.box_right) x.box_right = from.box_right;
        return x;
    endfunction

    function automatic entry_t new_entry(input coord_t r, input coord_t c);
        entry_t x;
        x.run_left = c;
        x.run_right = c;
        x.run_row = r;
        x.area = AREA_W'(1);
        x.row_sum = SUM_W'(r);
        x.col_sum = SUM_W'(c);
        x.box_top = r;
        x.box_bottom = r;
        x.box_left = c;
        x.box_right = c;
        return x;
    endfunction

endpackage

// ----- src/sbt_table.sv -----
// Blob table: one-read one-write entry memory with registered read data and
// per-entry live bits. Depends on sbt_pkg.
module sbt_table #(
    parameter int MAX_BLOBS = sbt_pkg::MAX_BLOBS_DEF,
    parameter int IDX_W = 6
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [IDX_W-1:0]    rd_addr,
    output sbt_pkg::entry_t     rd_data,
    input  logic                wr_en,
    input  logic [IDX_W-1:0]    wr_addr,
    input  sbt_pkg::entry_t     wr_data,
    input  sbt_pkg::vld_ctl_t   vctl,
    input  logic [IDX_W-1:0]    set_idx,
    input  logic [IDX_W-1:0]    clr_idx,
    output logic [MAX_BLOBS-1:0] live
);
    import sbt_pkg::*;

    entry_t mem [MAX_BLOBS];
    entry_t rd_data_reg;
    logic [MAX_BLOBS-1:0] live_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_reg <= '0;
        end
        else if (vctl.clear_all)
        begin
            live_reg <= '0;
        end
        else
        begin
            if (vctl.clr_en)
            begin
                live_reg[clr_idx] <= 1'b0;
            end
            if (vctl.set_en)
            begin
                live_reg[set_idx] <= 1'b1;
            end
        end
    end

    assign rd_data = rd_data_reg;
    assign live = live_reg;

endmodule

// ----- src/streaming_blob_tracker_unit.sv -----
// Streaming blob tracker top level: sequencer scanning the blob table one
// entry per cycle, update unit, report path. Depends on sbt_pkg, sbt_table.
//
//  channel | signals                                   | dir
//  --------+-------------------------------------------+----
//  input   | in_valid, in_stall, command, pixel_on,    | in
//          | row, column                               |
//  output  | out_valid, out_stall, blob_found, area,   | out
//          | top_row..column_total, table_overflow,last|
//  config  | cfg_wr_en, cfg_wr_data                    | in
//
// An on pixel runs a table scan that reads one entry per cycle through the single
// memory read port, then update and write-back (the write-back step is skipped
// when the pixel opens a new entry or is dropped). An off pixel does not stall
// the input. End of frame reads and checks each entry in turn, waits on any
// output stall, and clears the table at the end.
// in_stall is high whenever an item is in progress. Reset clears the table.
module streaming_blob_tracker_unit #(
    parameter int MAX_BLOBS = sbt_pkg::MAX_BLOBS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [sbt_pkg::THR_W-1:0]   cfg_wr_data,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        command,
    input  logic                        pixel_on,
    input  logic [sbt_pkg::COORD_BITS-1:0] row,
    input  logic [sbt_pkg::COORD_BITS-1:0] column,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        blob_found,
    output logic [sbt_pkg::AREA_W-1:0]  area,
    output logic [sbt_pkg::COORD_BITS-1:0] top_row,
    output logic [sbt_pkg::COORD_BITS-1:0] bottom_row,
    output logic [sbt_pkg::COORD_BITS-1:0] left_column,
    output logic [sbt_pkg::COORD_BITS-1:0] right_column,
    output logic [sbt_pkg::SUM_W-1:0]   row_total,
    output logic [sbt_pkg::SUM_W-1:0]   column_total,
    output logic                        table_overflow,
    output logic                        last
);
    import sbt_pkg::*;

    localparam int IDX_W = (MAX_BLOBS > 1) ? $clog2(MAX_BLOBS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_BLOBS - 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SCAN = 3'd1;
    localparam logic [2:0] ST_ADD  = 3'd2;
    localparam logic [2:0] ST_WR   = 3'd3;
    localparam logic [2:0] ST_RRD  = 3'd4;
    localparam logic [2:0] ST_RCHK = 3'd5;
    localparam logic [2:0] ST_REND = 3'd6;

    logic [2:0] state_reg, state_next;
    logic [THR_W-1:0] thr_reg;
    logic track_reg, track_next;
    logic [IDX_W-1:0] tracked_reg, tracked_next;
    logic ovf_reg, ovf_next;
    coord_t r_reg, c_reg;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic issue_done_reg, issue_done_next;
    logic chk_valid_reg, chk_valid_next;
    logic [IDX_W-1:0] chk_idx_reg, chk_idx_next;
    logic found_reg, found_next;
    logic [IDX_W-1:0] m_idx_reg, m_idx_next;
    logic free_found_reg, free_found_next;
    logic [IDX_W-1:0] free_idx_reg, free_idx_next;
    entry_t t_reg, t_next, m_reg, m_next, x_reg, x_next;
    logic pend_reg, pend_next;
    entry_t pend_data_reg, pend_data_next;

    logic out_valid_reg;
    logic out_found_reg, out_last_reg, out_ovf_reg;
    entry_t out_data_reg;
    logic out_load, out_found_in, out_last_in;
    entry_t out_data_in;

    logic [IDX_W-1:0] rd_addr, wr_addr, set_idx, clr_idx;
    entry_t rd_data, wr_data, base;
    logic wr_en;
    vld_ctl_t vctl;
    logic [MAX_BLOBS-1:0] live;

    logic in_xfer, out_free, is_match, qual;
    logic [COORD_BITS:0] c_p1, right_p1, row_p1;

    sbt_table #(
        .MAX_BLOBS(MAX_BLOBS),
        .IDX_W(IDX_W)
    ) u_table (
        .clk(clk),
        .rst_n(rst_n),
        .rd_addr(rd_addr),
        .rd_data(rd_data),
        .wr_en(wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .vctl(vctl),
        .set_idx(set_idx),
        .clr_idx(clr_idx),
        .live(live)
    );

    assign in_stall = (state_reg != ST_IDLE);
    assign in_xfer = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign rd_addr = idx_reg;

    // touch test against the previous row, diagonal contact included
    assign c_p1 = {1'b0, c_reg} + (COORD_BITS+1)'(1);
    assign right_p1 = {1'b0, rd_data.run_right} + (COORD_BITS+1)'(1);
    assign row_p1 = {1'b0, rd_data.run_row} + (COORD_BITS+1)'(1);
    assign is_match = (r_reg != '0) && (c_p1 >= {1'b0, rd_data.run_left})
                      && ({1'b0, c_reg} <= right_p1) && ({1'b0, r_reg} == row_p1);
    assign qual = live[chk_idx_reg] && (THR_W'(rd_data.area) > thr_reg);

    always_comb
    begin
        base = t_reg;
        if (!track_reg)
        begin
            base = m_reg;
            base.run_left = c_reg;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        track_next = track_reg;
        tracked_next = tracked_reg;
        ovf_next = ovf_reg;
        idx_next = idx_reg;
        issue_done_next = issue_done_reg;
        chk_valid_next = 1'b0;
        chk_idx_next = chk_idx_reg;
        found_next = found_reg;
        m_idx_next = m_idx_reg;
        free_found_next = free_found_reg;
        free_idx_next = free_idx_reg;
        t_next = t_reg;
        m_next = m_reg;
        x_next = x_reg;
        pend_next = pend_reg;
        pend_data_next = pend_data_reg;
        wr_en = 1'b0;
        wr_addr = m_idx_reg;
        wr_data = x_reg;
        vctl = '0;
        set_idx = m_idx_reg;
        clr_idx = tracked_reg;
        out_load = 1'b0;
        out_found_in = 1'b0;
        out_last_in = 1'b0;
        out_data_in = pend_data_reg;

        case (state_reg)
            ST_IDLE:
            begin
                idx_next = '0;
                chk_idx_next = '0;
                issue_done_next = 1'b0;
                found_next = 1'b0;
                free_found_next = 1'b0;
                pend_next = 1'b0;
                if (in_xfer)
                begin
                    if (command)
                    begin
                        state_next = ST_RRD;
                    end
                    else if (!pixel_on)
                    begin
                        track_next = 1'b0;
                    end
                    else
                    begin
                        if (column == '0)
                        begin
                            track_next = 1'b0;
                        end
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (!issue_done_reg)
                begin
                    chk_valid_next = 1'b1;
                    chk_idx_next = idx_reg;
                    if (idx_reg == LAST_IDX)
                    begin
                        issue_done_next = 1'b1;
                    end
                    else
                    begin
                        idx_next = idx_reg + IDX_W'(1);
                    end
                end
                if (chk_valid_reg)
                begin
                    if (track_reg && chk_idx_reg == tracked_reg)
                    begin
                        t_next = rd_data;
                    end
                    else if (live[chk_idx_reg] && is_match && !found_reg)
                    begin
                        found_next = 1'b1;
                        m_idx_next = chk_idx_reg;
                        m_next = rd_data;
                    end
                    if (!live[chk_idx_reg] && !free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_idx_next = chk_idx_reg;
                    end
                    if (chk_idx_reg == LAST_IDX)
                    begin
                        state_next = ST_ADD;
                    end
                end
            end
            ST_ADD:
            begin
                if (!track_reg && !found_reg)
                begin
                    state_next = ST_IDLE;
                    if (free_found_reg)
                    begin
                        wr_en = 1'b1;
                        wr_addr = free_idx_reg;
                        wr_data = new_entry(r_reg, c_reg);
                        vctl.set_en = 1'b1;
                        set_idx = free_idx_reg;
                        track_next = 1'b1;
                        tracked_next = free_idx_reg;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                end
                else
                begin
                    x_next = add_pixel(base, r_reg, c_reg);
                    state_next = ST_WR;
                end
            end
            ST_WR:
            begin
                wr_en = 1'b1;
                state_next = ST_IDLE;
                if (track_reg && found_reg)
                begin
                    wr_data = merge_entry(x_reg, m_reg);
                    vctl.clr_en = 1'b1;
                    tracked_next = m_idx_reg;
                end
                else if (track_reg)
                begin
                    wr_addr = tracked_reg;
                end
                else
                begin
                    track_next = 1'b1;
                    tracked_next = m_idx_reg;
                end
            end
            ST_RRD:
            begin
                chk_idx_next = idx_reg;
                state_next = ST_RCHK;
            end
            ST_RCHK:
            begin
                if (!(qual && pend_reg && !out_free))
                begin
                    if (qual)
                    begin
                        if (pend_reg)
                        begin
                            out_load = 1'b1;
                            out_found_in = 1'b1;
                        end
                        pend_next = 1'b1;
                        pend_data_next = rd_data;
                    end
                    if (idx_reg == LAST_IDX)
                    begin
                        state_next = ST_REND;
                    end
                    else
                    begin
                        idx_next = idx_reg + IDX_W'(1);
                        state_next = ST_RRD;
                    end
                end
            end
            ST_REND:
            begin
                if (out_free)
                begin
                    out_load = 1'b1;
                    out_last_in = 1'b1;
                    out_found_in = pend_reg;
                    if (!pend_reg)
                    begin
                        out_data_in = '0;
                    end
                    vctl.clear_all = 1'b1;
                    track_next = 1'b0;
                    ovf_next = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            thr_reg <= THRESH_RESET;
            track_reg <= 1'b0;
            tracked_reg <= '0;
            ovf_reg <= 1'b0;
            idx_reg <= '0;
            issue_done_reg <= 1'b0;
            chk_valid_reg <= 1'b0;
            chk_idx_reg <= '0;
            found_reg <= 1'b0;
            free_found_reg <= 1'b0;
            pend_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                thr_reg <= cfg_wr_data;
            end
            track_reg <= track_next;
            tracked_reg <= tracked_next;
            ovf_reg <= ovf_next;
            idx_reg <= idx_next;
            issue_done_reg <= issue_done_next;
            chk_valid_reg <= chk_valid_next;
            chk_idx_reg <= chk_idx_next;
            found_reg <= found_next;
            free_found_reg <= free_found_next;
            pend_reg <= pend_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            r_reg <= row;
            c_reg <= column;
        end
        m_idx_reg <= m_idx_next;
        free_idx_reg <= free_idx_next;
        t_reg <= t_next;
        m_reg <= m_next;
        x_reg <= x_next;
        pend_data_reg <= pend_data_next;
        if (out_load)
        begin
            out_found_reg <= out_found_in;
            out_last_reg <= out_last_in;
            out_ovf_reg <= ovf_reg;
            out_data_reg <= out_data_in;
        end
    end

    assign out_valid = out_valid_reg;
    assign blob_found = out_found_reg;
    assign area = out_data_reg.area;
    assign top_row = out_data_reg.box_top;
    assign bottom_row = out_data_reg.box_bottom;
    assign left_column = out_data_reg.box_left;
    assign right_column = out_data_reg.box_right;
    assign row_total = out_data_reg.row_sum;
    assign column_total = out_data_reg.col_sum;
    assign table_overflow = out_ovf_reg;
    assign last = out_last_reg;

    // a tracked blob always occupies a live entry
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && track_reg) |-> live[tracked_reg])
        else $error("tracked entry is not live");

    // the closing result of a report leaves the table empty
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_REND && out_free) |=> (live == '0 && !ovf_reg && !track_reg))
        else $error("table not cleared after report");

    // a result is only loaded while the output register can take it
    assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> out_free)
        else $error("result overwritten before transfer");

endmodule

// ----- dv/streaming_blob_tracker_unit_tb.sv -----
`timescale 1ns / 1ps
// Testbench for streaming_blob_tracker_unit: frames of raster-order patches and random pixels are driven, a
// behavioral blob table predicts the end-of-frame reports, and a monitor checks them.
// Depends on sbt_pkg (widths) and the RTL top level.
module streaming_blob_tracker_unit_tb;
    import sbt_pkg::*;

    localparam int NBLOB = 64;
    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_EOF = 1'b1;
    localparam logic [AREA_W-1:0] AREA_SAT = {AREA_W{1'b1}};
    localparam logic [SUM_W-1:0] SUM_SAT = {SUM_W{1'b1}};
    localparam longint CYCLE_LIMIT = 3000000;

    typedef struct packed {
        logic blob_found;
        logic [AREA_W-1:0] area;
        coord_t top_row;
        coord_t bottom_row;
        coord_t left_column;
        coord_t right_column;
        logic [SUM_W-1:0] row_total;
        logic [SUM_W-1:0] column_total;
        logic table_overflow;
        logic last;
    } report_t;

    typedef struct {
        coord_t lft, rgt, rw;
        logic [AREA_W-1:0] pix;
        logic [SUM_W-1:0] rsum, csum;
        coord_t top, bot, bl, br;
    } blob_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [THR_W-1:0] cfg_wr_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic command = 1'b0;
    logic pixel_on = 1'b0;
    coord_t row = '0;
    coord_t column = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic blob_found;
    logic [AREA_W-1:0] area;
    coord_t top_row, bottom_row, left_column, right_column;
    logic [SUM_W-1:0] row_total, column_total;
    logic table_overflow, last;

    blob_t blobs[NBLOB];
    logic tracking;
    int tracked;
    logic ovf;
    logic [THR_W-1:0] thresh;
    report_t pending_reports[$];
    int errors = 0;
    longint cycles = 0;
    int send_idle_pct = 0;
    int stall_pct = 0;
    int hold_cycles = 0;

    always #6 clk = ~clk;

    streaming_blob_tracker_unit dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .command(command), .pixel_on(pixel_on), .row(row), .column(column),
        .out_valid(out_valid), .out_stall(out_stall),
        .blob_found(blob_found), .area(area),
        .top_row(top_row), .bottom_row(bottom_row),
        .left_column(left_column), .right_column(right_column),
        .row_total(row_total), .column_total(column_total),
        .table_overflow(table_overflow), .last(last)
    );

    function automatic logic [AREA_W-1:0] area_add(logic [AREA_W-1:0] a, logic [AREA_W-1:0] b);
        logic [AREA_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[AREA_W] ? AREA_SAT : s[AREA_W-1:0];
    endfunction

    function automatic logic [SUM_W-1:0] sum_add(logic [SUM_W-1:0] a, logic [SUM_W-1:0] b);
        logic [SUM_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[SUM_W] ? SUM_SAT : s[SUM_W-1:0];
    endfunction

    function automatic void wipe_blob(int e);
        blobs[e] = '{default: '0};
    endfunction

    function automatic void wipe_table();
        for (int e = 0; e < NBLOB; e++) wipe_blob(e);
        tracking = 1'b0;
        tracked = 0;
        ovf = 1'b0;
    endfunction

    function automatic int touching_blob(coord_t r, coord_t c);
        if (r == 0) return -1;
        for (int e = 0; e < NBLOB; e++) begin
            if (blobs[e].pix == 0) continue;
            if (int'(c) + 1 >= int'(blobs[e].lft) && int'(c) <= int'(blobs[e].rgt) + 1 &&
                int'(r) == int'(blobs[e].rw) + 1)
                return e;
        end
        return -1;
    endfunction

    function automatic void grow_blob(int e, coord_t r, coord_t c);
        blobs[e].rgt = c;
        blobs[e].rw = r;
        blobs[e].pix = area_add(blobs[e].pix, 1);
        blobs[e].rsum = sum_add(blobs[e].rsum, SUM_W'(r));
        blobs[e].csum = sum_add(blobs[e].csum, SUM_W'(c));
        if (r < blobs[e].top) blobs[e].top = r;
        if (r > blobs[e].bot) blobs[e].bot = r;
        if (c < blobs[e].bl) blobs[e].bl = c;
        if (c > blobs[e].br) blobs[e].br = c;
    endfunction

    function automatic void fold_blob(int src, int dst);
        blobs[dst].lft = blobs[src].lft;
        blobs[dst].rgt = blobs[src].rgt;
        blobs[dst].rw = blobs[src].rw;
        blobs[dst].pix = area_add(blobs[dst].pix, blobs[src].pix);
        blobs[dst].rsum = sum_add(blobs[dst].rsum, blobs[src].rsum);
        blobs[dst].csum = sum_add(blobs[dst].csum, blobs[src].csum);
        if (blobs[src].top < blobs[dst].top) blobs[dst].top = blobs[src].top;
        if (blobs[src].bot > blobs[dst].bot) blobs[dst].bot = blobs[src].bot;
        if (blobs[src].bl < blobs[dst].bl) blobs[dst].bl = blobs[src].bl;
        if (blobs[src].br > blobs[dst].br) blobs[dst].br = blobs[src].br;
        wipe_blob(src);
    endfunction

    function automatic void track_pixel(coord_t r, coord_t c);
        int m;
        int e;
        if (c == 0) tracking = 1'b0;
        if (tracking) begin
            grow_blob(tracked, r, c);
            m = touching_blob(r, c);
            if (m >= 0 && m != tracked) begin
                fold_blob(tracked, m);
                tracked = m;
            end
            return;
        end
        m = touching_blob(r, c);
        if (m >= 0) begin
            blobs[m].lft = c;
            grow_blob(m, r, c);
            tracking = 1'b1;
            tracked = m;
            return;
        end
        for (e = 0; e < NBLOB; e++)
            if (blobs[e].pix == 0) break;
        if (e >= NBLOB) begin
            ovf = 1'b1;
            return;
        end
        blobs[e] = '{c, c, r, AREA_W'(1), SUM_W'(r), SUM_W'(c), r, r, c, c};
        tracking = 1'b1;
        tracked = e;
    endfunction

    function automatic void predict_item(logic cmd, logic on, coord_t r, coord_t c);
        report_t rep;
        int n;
        if (cmd == CMD_PIXEL) begin
            if (!on) tracking = 1'b0;
            else track_pixel(r, c);
            return;
        end
        n = 0;
        for (int e = 0; e < NBLOB; e++) begin
            if (blobs[e].pix <= AREA_W'(thresh)) continue;
            rep = '{1'b1, blobs[e].pix, blobs[e].top, blobs[e].bot, blobs[e].bl,
                    blobs[e].br, blobs[e].rsum, blobs[e].csum, ovf, 1'b0};
            pending_reports.push_back(rep);
            n++;
        end
        if (n == 0) begin
            rep = '0;
            rep.table_overflow = ovf;
            pending_reports.push_back(rep);
        end
        pending_reports[$].last = 1'b1;
        wipe_table();
    endfunction

    // sender side; valid drops at the falling edge where the next item is not offered
    task automatic send_item(logic cmd, logic on, coord_t r, coord_t c);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        command <= cmd;
        pixel_on <= on;
        row <= r;
        column <= c;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        predict_item(cmd, on, r, c);
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_reports.size() != 0) @(negedge clk);
        repeat (80) @(negedge clk);
    endtask

    task automatic write_threshold(logic [THR_W-1:0] v);
        drain();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        thresh = v;
    endtask

    task automatic set_idling(int s, int o);
        send_idle_pct = s;
        stall_pct = o;
    endtask

    // one rectangle-ish blob with random holes
    task automatic send_patch(coord_t r0, coord_t c0, int h, int w, int fill);
        for (int y = 0; y < h; y++)
            for (int x = 0; x < w; x++)
                send_item(CMD_PIXEL, $urandom_range(99) < fill, coord_t'(r0 + y),
                          coord_t'(c0 + x));
    endtask

    task automatic test_directed();
        set_idling(0, 0);
        send_item(CMD_EOF, 1'b1, '1, '1);
        write_threshold('0);
        send_item(CMD_PIXEL, 1'b1, 10'd0, 10'd0);
        send_item(CMD_PIXEL, 1'b1, 10'd0, 10'd1);
        send_item(CMD_PIXEL, 1'b0, 10'd0, 10'd2);
        send_item(CMD_PIXEL, 1'b1, 10'd0, 10'd3);
        send_item(CMD_PIXEL, 1'b1, 10'd1, 10'd0);
        send_item(CMD_PIXEL, 1'b1, 10'd1, 10'd1);
        send_item(CMD_PIXEL, 1'b1, 10'd1, 10'd2);
        send_item(CMD_PIXEL, 1'b1, 10'd1, 10'd4);
        send_item(CMD_PIXEL, 1'b1, 10'd2, 10'd5);
        send_item(CMD_PIXEL, 1'b1, 10'd1023, 10'd1023);
        send_item(CMD_PIXEL, 1'b1, 10'd1023, 10'd0);
        send_item(CMD_EOF, 1'b0, '0, '0);
        write_threshold({THR_W{1'b1}});
        send_item(CMD_PIXEL, 1'b1, 10'd5, 10'd5);
        send_item(CMD_EOF, 1'b0, '0, '0);
    endtask

    // isolated pixels, each closed by an off pixel, fill the table and overflow it
    task automatic test_overflow();
        write_threshold('0);
        set_idling(0, 55);
        for (int i = 0; i < 66; i++) begin
            send_item(CMD_PIXEL, 1'b1, 10'd2, coord_t'(2 * i + 1));
            send_item(CMD_PIXEL, 1'b0, 10'd2, coord_t'(2 * i + 2));
        end
        send_item(CMD_EOF, 1'b0, '0, '0);
    endtask

    task automatic test_random_frames();
        int frames;
        write_threshold(21'd3);
        frames = 0;
        repeat (8) begin
            case (frames % 4)
                0: set_idling(0, 0);
                1: set_idling(55, 0);
                2: set_idling(0, 55);
                default: set_idling(19, 19);
            endcase
            if (frames == 6) write_threshold(21'd1048576);
            if (frames == 7) write_threshold(21'd1);
            repeat ($urandom_range(1, 2))
                send_patch(coord_t'($urandom_range(0, 1018)), coord_t'($urandom_range(0, 1018)),
                           $urandom_range(1, 4), $urandom_range(1, 5), 75);
            repeat ($urandom_range(0, 3))
                send_item(CMD_PIXEL, 1'($urandom_range(0, 1)), coord_t'($urandom),
                          coord_t'($urandom));
            send_item(CMD_EOF, 1'($urandom_range(0, 1)), coord_t'($urandom),
                      coord_t'($urandom));
            frames++;
        end
    endtask

    task automatic test_backpressure();
        write_threshold(21'd0);
        set_idling(0, 0);
        send_patch(10'd40, 10'd40, 2, 3, 100);
        send_item(CMD_EOF, 1'b0, '0, '0);
        hold_cycles = 400;
        send_patch(10'd50, 10'd1, 1, 3, 100);
        send_item(CMD_EOF, 1'b0, '0, '0);
        send_item(CMD_PIXEL, 1'b1, 10'd3, 10'd3);
        drain();
        send_item(CMD_EOF, 1'b0, '0, '0);
    endtask

    // receiver side
    always @(negedge clk) begin
        if (hold_cycles > 0) begin
            out_stall <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end else begin
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge clk) begin
        report_t got;
        report_t want;
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
        if (rst_n && out_valid && !out_stall) begin
            got = '{blob_found, area, top_row, bottom_row, left_column, right_column,
                    row_total, column_total, table_overflow, last};
            if (pending_reports.size() == 0) begin
                $display("%0t: unexpected transfer %p", $time, got);
                errors++;
            end else begin
                want = pending_reports.pop_front();
                if (got !== want) begin
                    $display("%0t: mismatch expected %p actual %p", $time, want, got);
                    errors++;
                end
            end
        end
    end

    initial begin
        thresh = THRESH_RESET;
        wipe_table();
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed();
        test_overflow();
        test_random_frames();
        test_backpressure();
        drain();
        if (errors == 0 && pending_reports.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule

// ----- files.f -----
src/sbt_pkg.sv
src/sbt_table.sv
src/streaming_blob_tracker_unit.sv
dv/streaming_blob_tracker_unit_tb.sv
